// ----- sv/dog_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dog_pkg
// Shared types and constants of the 3x3 difference-of-Gaussians stream.
// ----------------------------------------------------------------------------
package dog_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 13;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int PIX_W      = 8;
    localparam int WT_W       = 16;
    localparam int SUM_W      = 10;
    localparam int PROD_W     = WT_W + SUM_W;
    localparam int ACC_W      = 28;
    localparam int FRAC_SHIFT = 8;
    localparam int ROUND_ADD  = 128;
    localparam int BLUR_W     = 16;
    localparam int DOG_W      = 17;

    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CORNER_A     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_EDGE_A       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_A     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CORNER_B     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_EDGE_B       = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_B     = 3'd7;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 12'd3;
    localparam logic [WT_W-1:0] CORNER_A_RESET = 16'd6237;
    localparam logic [WT_W-1:0] EDGE_A_RESET   = 16'd7744;
    localparam logic [WT_W-1:0] CENTER_A_RESET = 16'd9615;
    localparam logic [WT_W-1:0] CORNER_B_RESET = 16'd6622;
    localparam logic [WT_W-1:0] EDGE_B_RESET   = 16'd7588;
    localparam logic [WT_W-1:0] CENTER_B_RESET = 16'd8697;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam int PIPE_STAGES = 5;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } col_t;

    typedef struct packed {
        logic top_zero;
        logic bot_zero;
        logic left_zero;
        logic right_zero;
        logic last;
    } pos_flags_t;

    typedef struct packed {
        logic [BLUR_W-1:0]       blur_a;
        logic [BLUR_W-1:0]       blur_b;
        logic signed [DOG_W-1:0] dog_value;
        logic                    frame_last;
    } result_t;

endpackage
`default_nettype wire

// ----- sv/dog_line_buf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dog_line_buf
// Two line buffers packed in one memory word; write-first read port.
// ----------------------------------------------------------------------------
module dog_line_buf (
    input  wire logic                         aclk,
    input  wire logic                         rd_en,
    input  wire logic [dog_pkg::COL_W-1:0]    rd_addr,
    output logic      [2*dog_pkg::PIX_W-1:0]  rd_data,
    input  wire logic                         wr_en,
    input  wire logic [dog_pkg::COL_W-1:0]    wr_addr,
    input  wire logic [2*dog_pkg::PIX_W-1:0]  wr_data
);

    logic [2*dog_pkg::PIX_W-1:0] mem [dog_pkg::MAX_WIDTH];
    logic [2*dog_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- sv/dog_win_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dog_win_cell
// One column of the 3x3 window; hands its column to the next cell.
// ----------------------------------------------------------------------------
module dog_win_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          shift_en,
    input  wire dog_pkg::col_t col_in,
    output dog_pkg::col_t      col_out
);

    dog_pkg::col_t col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule
`default_nettype wire

// ----- sv/dog_blur.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dog_blur
// Symmetric 3x3 kernel: three products, rounding to Q8.8 and saturation.
// ----------------------------------------------------------------------------
module dog_blur (
    input  wire logic                          aclk,
    input  wire logic [dog_pkg::WT_W-1:0]      corner_weight,
    input  wire logic [dog_pkg::WT_W-1:0]      edge_weight,
    input  wire logic [dog_pkg::WT_W-1:0]      center_weight,
    input  wire logic [dog_pkg::SUM_W-1:0]     corner_sum,
    input  wire logic [dog_pkg::SUM_W-1:0]     edge_sum,
    input  wire logic [dog_pkg::PIX_W-1:0]     center_pix,
    output logic      [dog_pkg::BLUR_W-1:0]    blur
);

    localparam int SHIFTED_W = dog_pkg::ACC_W - dog_pkg::FRAC_SHIFT;

    logic [dog_pkg::PROD_W-1:0]             prod_c_reg;
    logic [dog_pkg::PROD_W-1:0]             prod_e_reg;
    logic [dog_pkg::WT_W+dog_pkg::PIX_W-1:0] prod_z_reg;
    logic [dog_pkg::ACC_W-1:0]              acc;
    logic [SHIFTED_W-1:0]                   shifted;
    logic [dog_pkg::BLUR_W-1:0]             blur_next;
    logic [dog_pkg::BLUR_W-1:0]             blur_reg;

    always_ff @(posedge aclk) begin
        prod_c_reg <= corner_weight * corner_sum;
        prod_e_reg <= edge_weight * edge_sum;
        prod_z_reg <= center_weight * center_pix;
        blur_reg   <= blur_next;
    end

    always_comb begin
        acc = dog_pkg::ACC_W'(prod_c_reg) + dog_pkg::ACC_W'(prod_e_reg)
            + dog_pkg::ACC_W'(prod_z_reg) + dog_pkg::ACC_W'(dog_pkg::ROUND_ADD);
        shifted = acc[dog_pkg::ACC_W-1:dog_pkg::FRAC_SHIFT];
        if (|shifted[SHIFTED_W-1:dog_pkg::BLUR_W]) begin
            blur_next = '1;
        end else begin
            blur_next = shifted[dog_pkg::BLUR_W-1:0];
        end
    end

    assign blur = blur_reg;

endmodule
`default_nettype wire

// ----- sv/dog_3x3_gaussian_stream.sv -----
`default_nettype none
// Results: a transaction's result passes the stage registers and the output queue before
// it is presented on the result channel, and results trail the pixel stream by image_width+1 transactions.
// Throughput: one transaction per cycle while s_ready is high, set by the line buffer
// read and the three-cell window chain that shift once per transaction.
// Reset: counters, geometry and weights return to their defaults; the line
// buffer is left as is, since stale entries only feed taps masked to zero.
// ----------------------------------------------------------------------------
// dog_3x3_gaussian_stream
// Streaming 3x3 difference-of-Gaussians with two configurable kernels.
// ----------------------------------------------------------------------------
module dog_3x3_gaussian_stream (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [dog_pkg::PIX_W-1:0]     s_pixel_in,
    input  wire logic                          s_flush,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [dog_pkg::BLUR_W-1:0]    m_blur_a,
    output logic      [dog_pkg::BLUR_W-1:0]    m_blur_b,
    output logic signed [dog_pkg::DOG_W-1:0]   m_dog_value,
    output logic                               m_frame_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dog_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [dog_pkg::DATA_W-1:0]    pwdata,
    output logic      [dog_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    // Configuration registers.
    logic [dog_pkg::WIDTH_W-1:0]  width_reg;
    logic [dog_pkg::HEIGHT_W-1:0] height_reg;
    logic [dog_pkg::WT_W-1:0]     corner_a_reg, edge_a_reg, center_a_reg;
    logic [dog_pkg::WT_W-1:0]     corner_b_reg, edge_b_reg, center_b_reg;
    logic                         cfg_wr;
    logic [dog_pkg::REG_IDX_W-1:0] cfg_idx;
    logic [dog_pkg::WIDTH_W-1:0]  width_next;
    logic [dog_pkg::HEIGHT_W-1:0] height_next;
    logic                         geom_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[dog_pkg::PADDR_W-1:2];
    assign geom_wr = cfg_wr && ((cfg_idx == dog_pkg::REG_IMAGE_WIDTH) ||
                                (cfg_idx == dog_pkg::REG_IMAGE_HEIGHT));

    always_comb begin
        width_next = pwdata[dog_pkg::WIDTH_W-1:0];
        if (width_next < dog_pkg::WIDTH_MIN) begin
            width_next = dog_pkg::WIDTH_MIN;
        end else if (width_next > dog_pkg::WIDTH_MAX) begin
            width_next = dog_pkg::WIDTH_MAX;
        end
        height_next = pwdata[dog_pkg::HEIGHT_W-1:0];
        if (height_next < dog_pkg::HEIGHT_MIN) begin
            height_next = dog_pkg::HEIGHT_MIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= dog_pkg::WIDTH_RESET;
            height_reg   <= dog_pkg::HEIGHT_RESET;
            corner_a_reg <= dog_pkg::CORNER_A_RESET;
            edge_a_reg   <= dog_pkg::EDGE_A_RESET;
            center_a_reg <= dog_pkg::CENTER_A_RESET;
            corner_b_reg <= dog_pkg::CORNER_B_RESET;
            edge_b_reg   <= dog_pkg::EDGE_B_RESET;
            center_b_reg <= dog_pkg::CENTER_B_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                dog_pkg::REG_IMAGE_WIDTH:  width_reg    <= width_next;
                dog_pkg::REG_IMAGE_HEIGHT: height_reg   <= height_next;
                dog_pkg::REG_CORNER_A:     corner_a_reg <= pwdata[dog_pkg::WT_W-1:0];
                dog_pkg::REG_EDGE_A:       edge_a_reg   <= pwdata[dog_pkg::WT_W-1:0];
                dog_pkg::REG_CENTER_A:     center_a_reg <= pwdata[dog_pkg::WT_W-1:0];
                dog_pkg::REG_CORNER_B:     corner_b_reg <= pwdata[dog_pkg::WT_W-1:0];
                dog_pkg::REG_EDGE_B:       edge_b_reg   <= pwdata[dog_pkg::WT_W-1:0];
                dog_pkg::REG_CENTER_B:     center_b_reg <= pwdata[dog_pkg::WT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            dog_pkg::REG_IMAGE_WIDTH:  prdata = dog_pkg::DATA_W'(width_reg);
            dog_pkg::REG_IMAGE_HEIGHT: prdata = dog_pkg::DATA_W'(height_reg);
            dog_pkg::REG_CORNER_A:     prdata = dog_pkg::DATA_W'(corner_a_reg);
            dog_pkg::REG_EDGE_A:       prdata = dog_pkg::DATA_W'(edge_a_reg);
            dog_pkg::REG_CENTER_A:     prdata = dog_pkg::DATA_W'(center_a_reg);
            dog_pkg::REG_CORNER_B:     prdata = dog_pkg::DATA_W'(corner_b_reg);
            dog_pkg::REG_EDGE_B:       prdata = dog_pkg::DATA_W'(edge_b_reg);
            dog_pkg::REG_CENTER_B:     prdata = dog_pkg::DATA_W'(center_b_reg);
            default:                   prdata = '0;
        endcase
    end

    // Position counters and per-transaction flags.
    logic                         s_accept;
    logic [dog_pkg::COL_W-1:0]    col_reg, col_next;
    logic [dog_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [dog_pkg::ROW_W-1:0]    h_ext, h_plus1;
    logic [dog_pkg::WIDTH_W-1:0]  col_inc;
    logic                         col_nz;
    logic                         has_res;
    logic [dog_pkg::PIX_W-1:0]    pix_v;
    dog_pkg::pos_flags_t          flags;

    assign s_accept = s_valid && s_ready;
    assign h_ext    = dog_pkg::ROW_W'(height_reg);
    assign h_plus1  = h_ext + dog_pkg::ROW_W'(1);
    assign col_inc  = dog_pkg::WIDTH_W'(col_reg) + dog_pkg::WIDTH_W'(1);
    assign col_nz   = (col_reg != '0);
    assign has_res  = (row_reg >= dog_pkg::ROW_W'(2)) ||
                      ((row_reg == dog_pkg::ROW_W'(1)) && col_nz);
    assign pix_v    = ((row_reg < h_ext) && !s_flush) ? s_pixel_in : '0;

    always_comb begin
        flags.top_zero   = col_nz ? (row_reg == dog_pkg::ROW_W'(1))
                                  : (row_reg == dog_pkg::ROW_W'(2));
        flags.bot_zero   = col_nz ? (row_reg >= h_ext) : (row_reg >= h_plus1);
        flags.left_zero  = (col_reg == dog_pkg::COL_W'(1));
        flags.right_zero = !col_nz;
        flags.last       = !col_nz && (row_reg == h_plus1);
        if (row_reg >= h_plus1) begin
            col_next = '0;
            row_next = '0;
        end else if (col_inc >= width_reg) begin
            col_next = '0;
            row_next = row_reg + dog_pkg::ROW_W'(1);
        end else begin
            col_next = col_inc[dog_pkg::COL_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (geom_wr) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1: line buffer read data returns.
    logic                        st1_valid_reg, st1_res_reg;
    dog_pkg::pos_flags_t         st1_flags_reg;
    logic [dog_pkg::PIX_W-1:0]   st1_pix_reg;
    logic [dog_pkg::COL_W-1:0]   st1_addr_reg;
    logic [2*dog_pkg::PIX_W-1:0] lb_rd_data;
    logic [dog_pkg::PIX_W-1:0]   lb_top, lb_mid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st1_res_reg   <= 1'b0;
        end else begin
            st1_valid_reg <= s_accept;
            st1_res_reg   <= s_accept && has_res;
        end
        st1_flags_reg <= flags;
        st1_pix_reg   <= pix_v;
        st1_addr_reg  <= col_reg;
    end

    dog_line_buf u_line_buf (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (col_reg),
        .rd_data (lb_rd_data),
        .wr_en   (st1_valid_reg),
        .wr_addr (st1_addr_reg),
        .wr_data ({lb_mid, st1_pix_reg})
    );

    assign lb_top = lb_rd_data[2*dog_pkg::PIX_W-1:dog_pkg::PIX_W];
    assign lb_mid = lb_rd_data[dog_pkg::PIX_W-1:0];

    // Window: a chain of three column cells, newest on the right.
    dog_pkg::col_t win_in  [3];
    dog_pkg::col_t win_col [3];

    assign win_in[2] = '{top: lb_top, mid: lb_mid, bot: st1_pix_reg};
    assign win_in[1] = win_col[2];
    assign win_in[0] = win_col[1];

    for (genvar gi = 0; gi < 3; gi++) begin : g_cell
        dog_win_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (st1_valid_reg),
            .col_in   (win_in[gi]),
            .col_out  (win_col[gi])
        );
    end

    // Stage 2: masked taps and their sums.
    logic                        st2_valid_reg;
    dog_pkg::pos_flags_t         st2_flags_reg;
    logic [dog_pkg::PIX_W-1:0]   tp [9];
    logic [dog_pkg::SUM_W-1:0]   csum_next, esum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_valid_reg <= 1'b0;
        end else begin
            st2_valid_reg <= st1_res_reg;
        end
        st2_flags_reg <= st1_flags_reg;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tp[k]     = win_col[k].top;
            tp[3 + k] = win_col[k].mid;
            tp[6 + k] = win_col[k].bot;
        end
        if (st2_flags_reg.top_zero) begin
            tp[0] = '0; tp[1] = '0; tp[2] = '0;
        end
        if (st2_flags_reg.bot_zero) begin
            tp[6] = '0; tp[7] = '0; tp[8] = '0;
        end
        if (st2_flags_reg.left_zero) begin
            tp[0] = '0; tp[3] = '0; tp[6] = '0;
        end
        if (st2_flags_reg.right_zero) begin
            tp[2] = '0; tp[5] = '0; tp[8] = '0;
        end
        csum_next = dog_pkg::SUM_W'(tp[0]) + dog_pkg::SUM_W'(tp[2])
                  + dog_pkg::SUM_W'(tp[6]) + dog_pkg::SUM_W'(tp[8]);
        esum_next = dog_pkg::SUM_W'(tp[1]) + dog_pkg::SUM_W'(tp[3])
                  + dog_pkg::SUM_W'(tp[5]) + dog_pkg::SUM_W'(tp[7]);
    end

    // Stages 3 to 5: sums, products, blurs.
    logic                        st3_valid_reg, st3_last_reg;
    logic                        st4_valid_reg, st4_last_reg;
    logic                        st5_valid_reg, st5_last_reg;
    logic [dog_pkg::SUM_W-1:0]   csum_reg, esum_reg;
    logic [dog_pkg::PIX_W-1:0]   ctr_reg;
    logic [dog_pkg::BLUR_W-1:0]  blur_a, blur_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
        end else begin
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
            st5_valid_reg <= st4_valid_reg;
        end
        st3_last_reg <= st2_flags_reg.last;
        st4_last_reg <= st3_last_reg;
        st5_last_reg <= st4_last_reg;
        csum_reg     <= csum_next;
        esum_reg     <= esum_next;
        ctr_reg      <= tp[4];
    end

    dog_blur u_blur_a (
        .aclk          (aclk),
        .corner_weight (corner_a_reg),
        .edge_weight   (edge_a_reg),
        .center_weight (center_a_reg),
        .corner_sum    (csum_reg),
        .edge_sum      (esum_reg),
        .center_pix    (ctr_reg),
        .blur          (blur_a)
    );

    dog_blur u_blur_b (
        .aclk          (aclk),
        .corner_weight (corner_b_reg),
        .edge_weight   (edge_b_reg),
        .center_weight (center_b_reg),
        .corner_sum    (csum_reg),
        .edge_sum      (esum_reg),
        .center_pix    (ctr_reg),
        .blur          (blur_b)
    );

    // Output queue; input is taken only while every transaction in flight has a slot.
    dog_pkg::result_t                fifo_mem [dog_pkg::FIFO_DEPTH];
    dog_pkg::result_t                push_data;
    logic [dog_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [dog_pkg::FIFO_CNT_W-1:0]  count_reg, count_next;
    logic [dog_pkg::FIFO_CNT_W:0]    occupancy;
    logic                            push, pop;

    assign push = st5_valid_reg;
    assign pop  = m_valid && m_ready;

    assign push_data.blur_a     = blur_a;
    assign push_data.blur_b     = blur_b;
    assign push_data.dog_value  = $signed({1'b0, blur_a}) - $signed({1'b0, blur_b});
    assign push_data.frame_last = st5_last_reg;

    assign occupancy = (dog_pkg::FIFO_CNT_W+1)'(count_reg)
                     + (dog_pkg::FIFO_CNT_W+1)'(st1_valid_reg)
                     + (dog_pkg::FIFO_CNT_W+1)'(st2_valid_reg)
                     + (dog_pkg::FIFO_CNT_W+1)'(st3_valid_reg)
                     + (dog_pkg::FIFO_CNT_W+1)'(st4_valid_reg)
                     + (dog_pkg::FIFO_CNT_W+1)'(st5_valid_reg);
    assign s_ready = (occupancy < (dog_pkg::FIFO_CNT_W+1)'(dog_pkg::FIFO_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + dog_pkg::FIFO_CNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - dog_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + dog_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + dog_pkg::FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign m_valid      = (count_reg != '0);
    assign m_blur_a     = fifo_mem[rd_ptr_reg].blur_a;
    assign m_blur_b     = fifo_mem[rd_ptr_reg].blur_b;
    assign m_dog_value  = fifo_mem[rd_ptr_reg].dog_value;
    assign m_frame_last = fifo_mem[rd_ptr_reg].frame_last;

endmodule
`default_nettype wire
